>>> hw/rtl/chacha_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha stream cipher package
// Shared item types, register indexes, controller commands and helpers.
// ----------------------------------------------------------------------------
package chacha_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 3'd5;

    localparam logic [4:0] ROUNDS_RESET = 5'd20;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646E;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2D32;
    localparam logic [31:0] SIGMA_3 = 32'h6B20_6574;

    typedef logic [15:0][31:0] t_state_words;
    typedef logic [3:0][63:0]  t_key;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        last_of_message;
    } t_in_item;

    typedef struct packed {
        logic [63:0] cipher_word;
        logic [3:0]  out_valid_bytes;
        logic        out_last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the input request into the input register
        logic load;      // load the working state from constants, key, counter, nonce
        logic step;      // one half quarter-round on all four lanes
        logic half;      // second half (rotations 8 and 7)
        logic diag;      // diagonal round rather than column round
        logic finish;    // add input state, store keystream, bump counter
        logic emit;      // write the result register; advance the position, or clear it at message end
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       pos_zero;
        logic [4:0] doubles;
    } t_dp_stat;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic t_state_words build_init(input t_key key, input logic [63:0] nonce,
                                                input logic [63:0] cnt);
        t_state_words s;
        s[0] = SIGMA_0;
        s[1] = SIGMA_1;
        s[2] = SIGMA_2;
        s[3] = SIGMA_3;
        for (int i = 0; i < 4; i++) begin
            s[4 + 2 * i] = key[i][31:0];
            s[5 + 2 * i] = key[i][63:32];
        end
        s[12] = cnt[31:0];
        s[13] = cnt[63:32];
        s[14] = nonce[31:0];
        s[15] = nonce[63:32];
        return s;
    endfunction

endpackage

>>> hw/rtl/chacha_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// ChaCha stream cipher, 64-bit nonce and 64-bit block counter
//
//   channel  direction  handshake                  payload
//   input    in         i_in_valid / o_in_ready    i_in_item   (t_in_item)
//   output   out        o_out_valid / i_out_ready  o_out_item  (t_out_item)
//   config   in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A request at word position zero is captured, loads the working state, runs
// ceil(R / 2) double rounds for R rounds, finishes and is emitted; any other
// request is captured and emitted. The shared four-lane unit does half a
// quarter-round per cycle. One request is in work at a time; a finished
// result waits in the output register while the next request is accepted.
// Reset is synchronous and clears key, nonce, counter and position, rounds to 20.
// ----------------------------------------------------------------------------
module chacha_stream_cipher_top
    import chacha_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    chacha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    chacha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_item  (o_out_item)
    );

    // A result is only written when the output register is free or being emptied.
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result written over a waiting result");

    // After a request is accepted nothing more is taken until it is done.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request accepted while one is in work");

    // The datapath is given at most one operation per cycle.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.capture, cmd.load, cmd.step, cmd.finish, cmd.emit}))
        else $error("conflicting datapath commands");

    // A new keystream block is only started at a 64-byte boundary.
    a_load_at_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> stat.pos_zero)
        else $error("keystream block started mid-block");

endmodule

>>> hw/rtl/chacha_ctrl.sv
// ----------------------------------------------------------------------------
// ChaCha controller
// Sequences request capture, block generation rounds and result emission.
// ----------------------------------------------------------------------------
module chacha_ctrl
    import chacha_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_FINAL = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic [6:0] steps;
    logic       last_step;
    logic       accept;
    logic       out_free;

    // Four half quarter-round steps per double round.
    assign steps     = {i_stat.doubles, 2'b00};
    assign last_step = ({1'b0, r_step} == (steps - 7'd1));
    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.half  = r_step[0];
        o_cmd.diag  = r_step[1];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_stat.pos_zero ? S_LOAD : S_EMIT;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = (i_stat.doubles == '0) ? S_FINAL : S_ROUND;
            end
            S_ROUND: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 6'd1;
                if (last_step) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.finish = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/chacha_dp.sv
// ----------------------------------------------------------------------------
// ChaCha datapath
// Configuration registers, working state with a four-lane quarter-round
// unit, keystream store, block counter, word position and result register.
// ----------------------------------------------------------------------------
module chacha_dp
    import chacha_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_item,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output t_out_item             o_out_item
);

    t_key         r_key;
    logic [63:0]  r_nonce;
    logic [4:0]   r_rounds;
    logic [63:0]  r_cnt;
    logic [2:0]   r_pos;
    t_state_words r_w, n_w;
    logic [63:0]  r_ks [8];
    t_in_item     r_in;
    t_out_item    r_out;

    t_state_words init;
    logic [5:0]   rounds_p1;
    logic [63:0]  mask;

    assign init      = build_init(r_key, r_nonce, r_cnt);
    assign rounds_p1 = {1'b0, r_rounds} + 6'd1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_nonce  <= '0;
            r_rounds <= ROUNDS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index) inside
                CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3: begin
                    r_key[i_cfg_index[1:0]] <= i_cfg_data;
                end
                CFG_NONCE: begin
                    r_nonce <= i_cfg_data;
                end
                CFG_ROUNDS: begin
                    r_rounds <= i_cfg_data[4:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Half a quarter-round on each of the four lanes. Lane j of a diagonal
    // round takes its b, c and d words rotated one, two and three places
    // along their rows.
    always_comb begin
        logic [3:0]  ia, ib, ic, id;
        logic [31:0] a1, b1, c1, d1, x, y;
        int          dg;
        n_w = r_w;
        dg  = i_cmd.diag ? 1 : 0;
        for (int j = 0; j < 4; j++) begin
            ia = 4'(j);
            ib = 4'(4 + ((j + dg) & 3));
            ic = 4'(8 + ((j + 2 * dg) & 3));
            id = 4'(12 + ((j + 3 * dg) & 3));
            a1 = r_w[ia] + r_w[ib];
            x  = r_w[id] ^ a1;
            d1 = i_cmd.half ? rotl32(x, 8) : rotl32(x, 16);
            c1 = r_w[ic] + d1;
            y  = r_w[ib] ^ c1;
            b1 = i_cmd.half ? rotl32(y, 7) : rotl32(y, 12);
            n_w[ia] = a1;
            n_w[ib] = b1;
            n_w[ic] = c1;
            n_w[id] = d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w <= init;
        end else if (i_cmd.step) begin
            r_w <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            for (int i = 0; i < 8; i++) begin
                r_ks[i] <= {r_w[2 * i + 1] + init[2 * i + 1], r_w[2 * i] + init[2 * i]};
            end
        end
    end

    // The counter is used for the block before it is bumped; the end of a
    // message sends both counter and position back to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pos <= '0;
        end else if (i_cmd.emit) begin
            if (r_in.last_of_message) begin
                r_cnt <= '0;
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 3'd1;
            end
        end else if (i_cmd.finish) begin
            r_cnt <= r_cnt + 64'd1;
        end
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            mask[8 * k +: 8] = (r_in.valid_bytes > 4'(k)) ? 8'hFF : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_item;
        end
        if (i_cmd.emit) begin
            r_out.cipher_word     <= (r_in.message_word ^ r_ks[r_pos]) & mask;
            r_out.out_valid_bytes <= r_in.valid_bytes;
            r_out.out_last        <= r_in.last_of_message;
        end
    end

    assign o_stat.pos_zero = (r_pos == '0);
    assign o_stat.doubles  = rounds_p1[5:1];
    assign o_out_item      = r_out;

endmodule
